### rtl/mas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mas_pkg
// Shared types, constants and helpers of the moving average block.
// ----------------------------------------------------------------------------
package mas_pkg;

  localparam int PriceW    = 32;
  localparam int WinW      = 9;
  localparam int SumW      = 40;
  localparam int SeenW     = 9;
  localparam int HistDepth = 256;
  localparam int HistAddrW = $clog2(HistDepth);
  localparam int ProdW     = PriceW + WinW;
  localparam int DivW      = 42;
  localparam int DenW      = WinW + 1;
  localparam int RemW      = WinW;
  localparam int DivCntW   = $clog2(DivW + 1);
  localparam int AddrW     = 3;

  localparam logic [SeenW-1:0] SeenMax     = '1;
  localparam logic [WinW-1:0]  WindowReset = WinW'(20);
  localparam logic [WinW-1:0]  WindowMax   = WinW'(HistDepth);

  localparam logic RegMode   = 1'b0;
  localparam logic RegWindow = 1'b1;

  typedef struct packed {
    logic [PriceW-1:0] close_price;
    logic              start_of_series;
  } in_word_t;

  typedef struct packed {
    logic [PriceW-1:0] average;
    logic              average_valid;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_start;
    logic finish;
  } mas_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } mas_status_t;

  function automatic logic [PriceW-1:0] sat_price(input logic [DivW-1:0] q);
    logic [PriceW-1:0] r;
    r = (|q[DivW-1:PriceW]) ? '1 : q[PriceW-1:0];
    return r;
  endfunction

  function automatic logic [WinW-1:0] eff_window(input logic [WinW-1:0] w);
    logic [WinW-1:0] r;
    if (w == '0) begin
      r = WinW'(1);
    end else if (w > WindowMax) begin
      r = WindowMax;
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/mas_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mas_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mas_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [mas_pkg::DivW-1:0]  num_i,
  input  wire logic [mas_pkg::DenW-1:0]  den_i,
  output logic                           busy_o,
  output logic [mas_pkg::DivW-1:0]       quot_o
);
  import mas_pkg::*;

  logic [DivW-1:0]    acc_q;
  logic [RemW-1:0]    rem_q;
  logic [DenW-1:0]    den_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DenW-1:0]    trial;
  logic               ge;

  assign trial = {rem_q, acc_q[DivW-1]};
  assign ge    = (trial >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DivCntW'(DivW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? RemW'(trial - den_q) : RemW'(trial);
      acc_q <= {acc_q[DivW-2:0], ge};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = acc_q;

endmodule
`default_nettype wire

### rtl/mas_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mas_ctrl
// Sequencer that steps one word at a time through the datapath.
// ----------------------------------------------------------------------------
module mas_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire mas_pkg::mas_status_t status_i,
  output mas_pkg::mas_cmd_t         cmd_o
);
  import mas_pkg::*;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StUpdate = 5'b00010,
    StStart  = 5'b00100,
    StWait   = 5'b01000,
    StFinish = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    in_ready_o       = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = StStart;
      end
      StStart: begin
        cmd_o.div_start = 1'b1;
        state_d         = StWait;
      end
      StWait: begin
        if (!status_i.div_busy) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### rtl/mas_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mas_datapath
// History memory, running sum, EMA state, two dividers and output register.
// ----------------------------------------------------------------------------
module mas_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mas_pkg::mas_cmd_t           cmd_i,
  output mas_pkg::mas_status_t             status_o,
  input  wire mas_pkg::in_word_t           in_word_i,
  input  wire logic                        mode_i,
  input  wire logic [mas_pkg::WinW-1:0]    window_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output mas_pkg::out_word_t               out_word_o
);
  import mas_pkg::*;

  logic [PriceW-1:0]    hist_mem [HistDepth];
  logic [PriceW-1:0]    rd_q;
  logic [HistAddrW-1:0] wp_q;
  logic [SumW-1:0]      sum_q;
  logic [SeenW-1:0]     seen_q;
  logic [PriceW-1:0]    ema_q;
  logic [PriceW-1:0]    x_q;
  logic [WinW-1:0]      w_q;
  logic [ProdW-1:0]     prod_q;
  logic                 pre_ge_q;
  logic                 post_ge_q;
  logic                 out_valid_q;
  out_word_t            out_word_q;

  logic [WinW-1:0]      w_eff;
  logic [HistAddrW-1:0] rd_idx;
  logic [SeenW-1:0]     seen_next;
  logic                 pre_ge;
  logic [SumW-1:0]      sub_val;
  logic [DivW-1:0]      num_sma;
  logic [DivW-1:0]      num_ema;
  logic [DenW-1:0]      den_sma;
  logic [DenW-1:0]      den_ema;
  logic                 busy_sma;
  logic                 busy_ema;
  logic [DivW-1:0]      q_sma;
  logic [DivW-1:0]      q_ema;
  logic [PriceW-1:0]    sma;
  logic [PriceW-1:0]    ema_new;

  assign w_eff     = eff_window(window_i);
  assign rd_idx    = wp_q - w_eff[HistAddrW-1:0];
  assign pre_ge    = (seen_q >= w_q);
  assign seen_next = (seen_q == SeenMax) ? SeenMax : seen_q + SeenW'(1);
  assign sub_val   = pre_ge ? SumW'(rd_q) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q <= hist_mem[rd_idx];
    end
    if (cmd_i.update) begin
      hist_mem[wp_q] <= x_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      sum_q  <= '0;
      seen_q <= '0;
      ema_q  <= '0;
    end else begin
      if (cmd_i.accept && in_word_i.start_of_series) begin
        sum_q  <= '0;
        seen_q <= '0;
        ema_q  <= '0;
      end
      if (cmd_i.update) begin
        sum_q  <= sum_q + SumW'(x_q) - sub_val;
        seen_q <= seen_next;
        wp_q   <= wp_q + HistAddrW'(1);
      end
      if (cmd_i.finish) begin
        ema_q <= ema_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= in_word_i.close_price;
      w_q <= w_eff;
    end
    if (cmd_i.update) begin
      pre_ge_q  <= pre_ge;
      post_ge_q <= (seen_next >= w_q);
      prod_q    <= ProdW'(ema_q) * ProdW'(w_q - WinW'(1));
    end
  end

  assign den_sma = DenW'(w_q);
  assign den_ema = DenW'(w_q) + DenW'(1);
  assign num_sma = DivW'(sum_q) + DivW'(w_q >> 1);
  assign num_ema = DivW'(prod_q) + (DivW'(x_q) << 1) + DivW'(den_ema >> 1);

  mas_div u_div_sma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_sma),
    .den_i   (den_sma),
    .busy_o  (busy_sma),
    .quot_o  (q_sma)
  );

  mas_div u_div_ema (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_ema),
    .den_i   (den_ema),
    .busy_o  (busy_ema),
    .quot_o  (q_ema)
  );

  assign sma = sat_price(q_sma);

  always_comb begin
    if (pre_ge_q) begin
      ema_new = sat_price(q_ema);
    end else if (post_ge_q) begin
      ema_new = sma;
    end else begin
      ema_new = ema_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_word_q.average_valid <= post_ge_q;
      if (!post_ge_q) begin
        out_word_q.average <= '0;
      end else if (mode_i) begin
        out_word_q.average <= ema_new;
      end else begin
        out_word_q.average <= sma;
      end
    end
  end

  assign status_o.div_busy = busy_sma | busy_ema;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_word_o        = out_word_q;

endmodule
`default_nettype wire

### rtl/moving_average_sma_ema.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// moving_average_sma_ema
// Simple and exponential moving average of a Q16.16 price stream.
// ----------------------------------------------------------------------------
// Each accepted word steps through update, divider start, the 42-step
// radix-2 dividers that run for both averages, and finish, before its result word is offered.
// One word is in flight at a time, so a new word is not taken until the last
// result word is done, and that result may first wait for the output side.
// Reset clears the pointer, sum, count, EMA value, configuration registers and handshakes;
// the history memory is not cleared and needs no clearing pass.
module moving_average_sma_ema (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire mas_pkg::in_word_t           in_word_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output mas_pkg::out_word_t               out_word_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mas_pkg::AddrW-1:0]   paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import mas_pkg::*;

  logic            mode_q;
  logic [WinW-1:0] window_q;
  logic            reg_wr;
  mas_cmd_t        cmd;
  mas_status_t     status;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      window_q <= WindowReset;
    end else if (reg_wr) begin
      if (paddr[2] == RegMode) begin
        mode_q <= pwdata[0];
      end else begin
        window_q <= pwdata[WinW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == RegWindow) begin
      prdata = 32'(window_q);
    end else begin
      prdata = 32'(mode_q);
    end
  end

  mas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mas_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_word_i   (in_word_i),
    .mode_i      (mode_q),
    .window_i    (window_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

### bench/moving_average_sma_ema_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_sma_ema_tb
// Self-checking bench for the SMA/EMA price averager. A scoreboard class
// tracks the delay line, running sum, sample count and EMA value for every
// accepted price word, and compares each result word with its prediction.
// Stimulus is a directed opening followed by random price series under many
// register settings and idle profiles.
// ----------------------------------------------------------------------------

class average_tracker;
  bit                  mode;
  bit [8:0]            window_reg;
  bit [31:0]           history [256];
  bit [7:0]            wr_ptr;
  bit [39:0]           run_sum;
  bit [8:0]            seen;
  bit [31:0]           ema;
  mas_pkg::out_word_t  expected_q [$];
  int                  words_in;
  int                  words_out;
  int                  valid_count;
  int                  mismatches;

  function new();
    mode       = 1'b0;
    window_reg = 9'd20;
    wr_ptr     = '0;
    run_sum    = '0;
    seen       = '0;
    ema        = '0;
    foreach (history[i]) history[i] = '0;
  endfunction

  function bit [31:0] rounded_quotient(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (num + den / 2) / den;
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function mas_pkg::out_word_t predict_average(mas_pkg::in_word_t w);
    mas_pkg::out_word_t r;
    longint unsigned    win;
    longint unsigned    pre;
    longint unsigned    post;
    bit [31:0]          sma;
    bit [7:0]           old_idx;
    if (window_reg == 0) begin
      win = 1;
    end else if (window_reg > 256) begin
      win = 256;
    end else begin
      win = window_reg;
    end
    if (w.start_of_series) begin
      seen    = '0;
      run_sum = '0;
      ema     = '0;
    end
    pre     = seen;
    old_idx = wr_ptr - 8'(win);
    run_sum = run_sum + 40'(w.close_price);
    if (pre >= win) begin
      run_sum = run_sum - 40'(history[old_idx]);
    end
    history[wr_ptr] = w.close_price;
    wr_ptr = wr_ptr + 8'd1;
    post = (pre < 511) ? pre + 1 : 511;
    seen = post[8:0];
    sma  = rounded_quotient(64'(run_sum), win);
    if (pre < win) begin
      if (post >= win) begin
        ema = sma;
      end
    end else begin
      ema = rounded_quotient(64'(ema) * (win - 1) + 64'(w.close_price) * 2, win + 1);
    end
    r.average_valid = (post >= win);
    r.average       = r.average_valid ? (mode ? ema : sma) : '0;
    return r;
  endfunction

  function void note_word(mas_pkg::in_word_t w);
    expected_q.push_back(predict_average(w));
    words_in++;
  endfunction

  function void log_mismatch(string field, longint unsigned exp_v, longint unsigned got_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch at %0t on %s: expected 0x%0h, got 0x%0h", $time, field, exp_v,
               got_v);
    end
  endfunction

  function void check_word(mas_pkg::out_word_t got);
    mas_pkg::out_word_t exp_w;
    words_out++;
    if (expected_q.size() == 0) begin
      log_mismatch("unexpected result word (average)", 0, got.average);
    end else begin
      exp_w = expected_q.pop_front();
      if (exp_w.average_valid) valid_count++;
      if (got.average !== exp_w.average) begin
        log_mismatch("average", exp_w.average, got.average);
      end
      if (got.average_valid !== exp_w.average_valid) begin
        log_mismatch("average_valid", exp_w.average_valid, got.average_valid);
      end
    end
  endfunction
endclass

module moving_average_sma_ema_tb;
  import mas_pkg::*;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_word_t         in_word_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_word_t        out_word_o;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [31:0]      pwdata      = '0;
  logic [31:0]      prdata;
  logic             pready;

  average_tracker tracker = new();

  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        hold_left      = 0;
  int        settings_count = 0;
  bit [31:0] walk_price     = 32'h0064_0000;

  moving_average_sma_ema u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_word(out_word_o);
    end
  end

  function automatic in_word_t make_word(bit [31:0] price, bit start);
    in_word_t w;
    w.close_price     = price;
    w.start_of_series = start;
    return w;
  endfunction

  function automatic bit [31:0] pick_price();
    bit [31:0] p;
    case ($urandom_range(9))
      0: p = '0;
      1: p = '1;
      2, 3: p = $urandom;
      default: begin
        walk_price = walk_price + $urandom_range(32'h4_0000) - 32'h2_0000;
        p = walk_price;
      end
    endcase
    return p;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    tracker.note_word(w);
  endtask

  task automatic wait_for_averages();
    in_valid_i <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input bit [31:0] value);
    wait_for_averages();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= AddrW'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegMode) begin
      tracker.mode = value[0];
    end else begin
      tracker.window_reg = value[8:0];
    end
    settings_count++;
  endtask

  task automatic set_idle_profile(input int profile);
    case (profile)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
      default: begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
  endtask

  task automatic run_series(input int count, input bit restarts);
    int eff;
    bit start;
    eff = (tracker.window_reg == 0) ? 1 :
          (tracker.window_reg > 256) ? 256 : int'(tracker.window_reg);
    for (int i = 0; i < count; i++) begin
      start = (i == 0) || (restarts && $urandom_range(3 * eff + 10) == 0);
      send_word(make_word(pick_price(), start));
    end
  endtask

  initial begin
    int sel;
    int win;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_register(RegMode, 0);
    write_register(RegWindow, 1);
    send_word(make_word(32'h0000_0000, 1'b1));
    send_word(make_word(32'hFFFF_FFFF, 1'b0));
    send_word(make_word(32'h8000_0001, 1'b0));

    write_register(RegMode, 1);
    write_register(RegWindow, 0);
    send_word(make_word(32'hFFFF_FFFF, 1'b1));
    send_word(make_word(32'h0000_0000, 1'b0));
    send_word(make_word(32'h0001_0000, 1'b0));

    write_register(RegWindow, 4);
    repeat (4) send_word(make_word(32'hFFFF_FFFF, 1'b0 == 1'b1));
    send_word(make_word(32'h0000_0000, 1'b0));
    send_word(make_word(32'hFFFF_FFFF, 1'b0));
    send_word(make_word(32'h1234_5678, 1'b0));

    // Shrinking the window mid-series leaves the old sum, so the SMA saturates.
    write_register(RegWindow, 1);
    write_register(RegMode, 0);
    send_word(make_word(32'hFFFF_FFFF, 1'b0));
    send_word(make_word(32'h0000_0000, 1'b0));

    // Growing it mid-series to the current sample count keeps updating the EMA without a reseed.
    write_register(RegWindow, 12);
    write_register(RegMode, 1);
    repeat (4) send_word(make_word(32'h0064_0000, 1'b0));

    for (int phase = 0; phase < 11; phase++) begin
      sel = $urandom_range(9);
      case (sel)
        0: win = 0;
        1: win = $urandom_range(511, 257);
        2: win = 256;
        3, 4: win = $urandom_range(120, 17);
        default: win = $urandom_range(16, 1);
      endcase
      write_register(RegMode, $urandom_range(1));
      write_register(RegWindow, win);
      set_idle_profile(phase % 4);
      if (phase == 2) begin
        @(negedge clk_i);
        hold_left = 300;
        @(posedge clk_i);
      end
      run_series(100, 1'b1);
    end

    // One long series at the widest window drives the sample count to its limit.
    write_register(RegMode, $urandom_range(1));
    write_register(RegWindow, 256);
    set_idle_profile(3);
    run_series(530, 1'b0);

    wait_for_averages();
    repeat (60) @(posedge clk_i);
    if (tracker.expected_q.size() != 0) begin
      tracker.mismatches += tracker.expected_q.size();
    end
    $display("Covered %0d price words over %0d register writes, SMA and EMA, windows 0 to 511.",
             tracker.words_in, settings_count);
    $display("Checked %0d result words, %0d of them valid averages, %0d mismatches.",
             tracker.words_out, tracker.valid_count, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("** moving_average_sma_ema: PASSED **");
    end else begin
      $display("** moving_average_sma_ema: FAILED **");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("Timeout with %0d result words still expected.", tracker.expected_q.size());
    $display("** moving_average_sma_ema: FAILED **");
    $finish;
  end

endmodule
